// ===== sv/cell_adc_diagnostic_sequencer_defines.svh =====
// Assertion macros shared by the cell ADC diagnostic sequencer modules.
`ifndef CELL_ADC_DIAGNOSTIC_SEQUENCER_DEFINES_SVH
`define CELL_ADC_DIAGNOSTIC_SEQUENCER_DEFINES_SVH

// Property that must hold at every clock edge outside of reset.
`define CADS_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CADS_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/cads_pkg.sv =====
// Shared types, codes and defaults of the cell ADC diagnostic sequencer.
package cads_pkg;

    // Default sizes of the monitor chain.
    localparam int NUM_MODULES_DEF      = 8;
    localparam int NUM_PHASES_DEF       = 4;
    localparam int CELLS_PER_MODULE_DEF = 16;

    // Field widths fixed by the stream format.
    localparam int MOD_W   = 3;
    localparam int CELL_W  = 4;
    localparam int CODE_W  = 16;
    localparam int PHASE_W = 3;
    localparam int KIND_W  = 2;
    localparam int MAP_W   = 17;
    localparam int LIMIT_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;
    // At most eight modules are reported after an open-wire phase.
    localparam int MAX_REPORTS = 8;
    localparam int RPT_IDX_W   = 3;

    // Request kinds on the input stream.
    localparam logic REQ_SAMPLE   = 1'b0;
    localparam logic REQ_END_PASS = 1'b1;

    // Result kinds on the output stream.
    localparam logic [KIND_W-1:0] KIND_CHECK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REPORT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd2;

    // Diagnostic phases; phases above the even open-wire phase are pauses.
    localparam logic [PHASE_W-1:0] PH_REDUNDANT = 3'd0;
    localparam logic [PHASE_W-1:0] PH_OW_ODD    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_OW_EVEN   = 3'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH_LIMIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_WIRE_LIMIT = 1'b1;

    // Register defaults: 0.2 V difference and -1.0 V threshold in raw codes.
    localparam logic [LIMIT_W-1:0] MISMATCH_LIMIT_RST  = 16'd1333;
    localparam logic [LIMIT_W-1:0] OPEN_WIRE_LIMIT_RST = 16'hE5F6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                 in_ready;
        logic                 rpt_load;
        logic                 rpt_last;
        logic [RPT_IDX_W-1:0] rpt_idx;
    } cads_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic eop_report;
    } cads_sts_t;

endpackage

// ===== sv/cads_ctrl.sv =====
// Controller state machine: input admission and the open-wire report sweep.
`include "cell_adc_diagnostic_sequencer_defines.svh"

module cads_ctrl #(
    parameter int NUM_MODULES = cads_pkg::NUM_MODULES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cads_pkg::cads_sts_t sts,
    output cads_pkg::cads_cmd_t cmd
);
    import cads_pkg::*;

    localparam int RPT_COUNT = (NUM_MODULES < MAX_REPORTS) ? NUM_MODULES : MAX_REPORTS;
    localparam logic [RPT_IDX_W-1:0] RPT_LAST_IDX = RPT_IDX_W'(RPT_COUNT - 1);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_REPORT = 1'b1;

    logic                 state_reg, state_next;
    logic [RPT_IDX_W-1:0] cnt_reg, cnt_next;
    logic                 accept;

    // Requests are taken only when idle and the output register can take a result.
    assign cmd.in_ready = (state_reg == ST_IDLE) && sts.out_free;
    assign accept       = sts.in_valid && cmd.in_ready;
    assign cmd.rpt_load = (state_reg == ST_REPORT) && sts.out_free;
    assign cmd.rpt_idx  = cnt_reg;
    assign cmd.rpt_last = (cnt_reg == RPT_LAST_IDX);

    // Next state: a sweep starts on an end-of-pass request after an open-wire phase and ends with the last report.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && sts.eop_report) begin
                    state_next = ST_REPORT;
                    cnt_next   = '0;
                end
            end
            ST_REPORT: begin
                if (cmd.rpt_load) begin
                    if (cmd.rpt_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and sweep counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    `CADS_CHECK(a_no_take_in_sweep, (state_reg == ST_REPORT) |-> !cmd.in_ready, "request taken during report sweep")
    `CADS_CHECK(a_cnt_in_range, cnt_reg <= RPT_LAST_IDX, "report counter beyond module count")
    `CADS_CHECK_NEXT(a_sweep_ends, cmd.rpt_load && cmd.rpt_last, state_reg == ST_IDLE, "sweep did not end after last report")

endmodule

// ===== sv/cads_dpath.sv =====
// Datapath: limits, phase, low-cell masks, checks and the output register.
`include "cell_adc_diagnostic_sequencer_defines.svh"

module cads_dpath #(
    parameter int NUM_MODULES      = cads_pkg::NUM_MODULES_DEF,
    parameter int NUM_PHASES       = cads_pkg::NUM_PHASES_DEF,
    parameter int CELLS_PER_MODULE = cads_pkg::CELLS_PER_MODULE_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration writes.
    input  logic                               cfg_valid,
    input  logic [cads_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cads_pkg::LIMIT_W-1:0]       cfg_data,
    // Input request fields.
    input  logic                               in_valid,
    input  logic                               req_type,
    input  logic [cads_pkg::MOD_W-1:0]         module_index,
    input  logic [cads_pkg::CELL_W-1:0]        cell_index,
    input  logic signed [cads_pkg::CODE_W-1:0] primary_code,
    input  logic signed [cads_pkg::CODE_W-1:0] redundant_code,
    // Result fields.
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic [cads_pkg::KIND_W-1:0]        kind,
    output logic [cads_pkg::MOD_W-1:0]         out_module,
    output logic [cads_pkg::CELL_W-1:0]        out_cell,
    output logic                               mismatch_valid,
    output logic                               mismatch,
    output logic [cads_pkg::MAP_W-1:0]         open_wire_map,
    output logic [cads_pkg::PHASE_W-1:0]       phase,
    output logic                               last,
    // Controller link.
    input  cads_pkg::cads_cmd_t                cmd,
    output cads_pkg::cads_sts_t                sts
);
    import cads_pkg::*;

    localparam int MASK_DEPTH = (NUM_MODULES < MAX_REPORTS) ? NUM_MODULES : MAX_REPORTS;
    localparam int MIDX_W     = (MASK_DEPTH > 1) ? $clog2(MASK_DEPTH) : 1;
    localparam int CIDX_W     = $clog2(CELLS_PER_MODULE);
    localparam logic [PHASE_W-1:0] PH_LAST = PHASE_W'(NUM_PHASES - 1);

    logic [LIMIT_W-1:0]          mm_limit_reg;
    logic signed [LIMIT_W-1:0]   ow_limit_reg;
    logic [PHASE_W-1:0]          phase_reg, phase_next;
    logic [CELLS_PER_MODULE-1:0] mask_reg [MASK_DEPTH];

    logic                        out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]           kind_reg, kind_next;
    logic [MOD_W-1:0]            mod_reg, mod_next;
    logic [CELL_W-1:0]           cell_reg, cell_next;
    logic                        mv_reg, mv_next;
    logic                        mm_reg, mm_next;
    logic [MAP_W-1:0]            map_reg, map_next;
    logic [PHASE_W-1:0]          ph_out_reg, ph_out_next;
    logic                        last_reg, last_next;

    logic                        accept;
    logic                        in_range;
    logic                        check_phase;
    logic                        ow_phase;
    logic                        load_check;
    logic                        load_adv;
    logic                        mask_wr;
    logic                        cell_low;
    logic signed [CODE_W:0]      diff;
    logic [CODE_W:0]             abs_diff;
    logic [CELLS_PER_MODULE-1:0] rpt_mask;
    logic [MAP_W-1:0]            wire_map;
    logic [MIDX_W-1:0]           wr_idx;
    logic [CIDX_W-1:0]           wr_bit;

    // Request decode.
    assign accept      = in_valid && cmd.in_ready;
    assign in_range    = ({{(6 - MOD_W){1'b0}}, module_index} < 6'(NUM_MODULES))
                         && ({1'b0, cell_index} < 5'(CELLS_PER_MODULE));
    assign check_phase = (phase_reg <= PH_OW_EVEN);
    assign ow_phase    = (phase_reg == PH_OW_ODD) || (phase_reg == PH_OW_EVEN);
    assign load_check  = accept && (req_type == REQ_SAMPLE) && check_phase && in_range;
    assign load_adv    = accept && (req_type == REQ_END_PASS) && !ow_phase;

    assign sts.in_valid   = in_valid;
    assign sts.out_free   = !out_valid_reg || out_ready;
    assign sts.eop_report = (req_type == REQ_END_PASS) && ow_phase;

    // Redundant check: absolute code difference against the limit.
    assign diff     = (CODE_W + 1)'(primary_code) - (CODE_W + 1)'(redundant_code);
    assign abs_diff = diff[CODE_W] ? (CODE_W + 1)'(-diff) : (CODE_W + 1)'(diff);

    // Open-wire sampling: tested parity only, low when below the threshold.
    assign mask_wr  = load_check && (((phase_reg == PH_OW_ODD) && cell_index[0])
                      || ((phase_reg == PH_OW_EVEN) && !cell_index[0]));
    assign cell_low = (redundant_code < ow_limit_reg);
    assign wr_idx   = module_index[MIDX_W-1:0];
    assign wr_bit   = cell_index[CIDX_W-1:0];

    // Sense wire map of the module under report.
    assign rpt_mask = mask_reg[cmd.rpt_idx[MIDX_W-1:0]];
    always_comb begin
        wire_map    = '0;
        for (int j = 1; j < CELLS_PER_MODULE; j++) begin
            wire_map[j] = rpt_mask[j-1] && rpt_mask[j];
        end
        wire_map[0] = rpt_mask[0] && !rpt_mask[1];
        wire_map[CELLS_PER_MODULE] = rpt_mask[CELLS_PER_MODULE-1]
                                     && !rpt_mask[CELLS_PER_MODULE-2];
    end

    // Phase advances modulo the phase count on every end-of-pass request.
    always_comb begin
        phase_next = phase_reg;
        if (accept && (req_type == REQ_END_PASS)) begin
            phase_next = (phase_reg == PH_LAST) ? '0 : phase_reg + 1'b1;
        end
    end

    // Output register contents.
    always_comb begin
        kind_next   = kind_reg;
        mod_next    = mod_reg;
        cell_next   = cell_reg;
        mv_next     = mv_reg;
        mm_next     = mm_reg;
        map_next    = map_reg;
        ph_out_next = ph_out_reg;
        last_next   = last_reg;
        priority if (cmd.rpt_load) begin
            kind_next   = KIND_REPORT;
            mod_next    = MOD_W'(cmd.rpt_idx);
            cell_next   = '0;
            mv_next     = 1'b0;
            mm_next     = 1'b0;
            map_next    = wire_map;
            ph_out_next = phase_reg;
            last_next   = cmd.rpt_last;
        end else if (load_check) begin
            kind_next   = KIND_CHECK;
            mod_next    = module_index;
            cell_next   = cell_index;
            mv_next     = (phase_reg == PH_REDUNDANT);
            mm_next     = (phase_reg == PH_REDUNDANT)
                          && (abs_diff > {1'b0, mm_limit_reg});
            map_next    = '0;
            ph_out_next = phase_reg;
            last_next   = 1'b1;
        end else if (load_adv) begin
            kind_next   = KIND_ADVANCE;
            mod_next    = '0;
            cell_next   = '0;
            mv_next     = 1'b0;
            mm_next     = 1'b0;
            map_next    = '0;
            ph_out_next = phase_next;
            last_next   = 1'b1;
        end
    end

    // Output valid flag.
    always_comb begin
        priority if (cmd.rpt_load || load_check || load_adv) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state, limits and masks.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mm_limit_reg  <= MISMATCH_LIMIT_RST;
            ow_limit_reg  <= OPEN_WIRE_LIMIT_RST;
            phase_reg     <= PH_REDUNDANT;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MASK_DEPTH; i++) begin
                mask_reg[i] <= '0;
            end
        end else begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_MISMATCH_LIMIT:  mm_limit_reg <= cfg_data;
                    CFG_OPEN_WIRE_LIMIT: ow_limit_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (mask_wr) begin
                mask_reg[wr_idx][wr_bit] <= cell_low;
            end
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        mod_reg    <= mod_next;
        cell_reg   <= cell_next;
        mv_reg     <= mv_next;
        mm_reg     <= mm_next;
        map_reg    <= map_next;
        ph_out_reg <= ph_out_next;
        last_reg   <= last_next;
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign out_module     = mod_reg;
    assign out_cell       = cell_reg;
    assign mismatch_valid = mv_reg;
    assign mismatch       = mm_reg;
    assign open_wire_map  = map_reg;
    assign phase          = ph_out_reg;
    assign last           = last_reg;

    `CADS_CHECK(a_phase_in_range, phase_reg <= PH_LAST, "phase beyond phase count")
    `CADS_CHECK(a_load_when_free, (cmd.rpt_load || load_check || load_adv) |-> sts.out_free, "result loaded over a pending result")
    `CADS_CHECK(a_report_no_check, (out_valid_reg && (kind_reg != KIND_CHECK)) |-> (!mv_reg && !mm_reg && (cell_reg == '0)), "report carries check fields")

endmodule

// ===== sv/cell_adc_diagnostic_sequencer.sv =====
// Top level of the cell ADC diagnostic sequencer: stream ports, controller and datapath.
// Checks and advances show in the cycle after accept; reports follow from the report state.
// Throughput: cell samples and plain phase advances are taken one per cycle while the output is free.
// An end of pass after an open-wire phase starts a sweep of min(NUM_MODULES, 8) reports,
// one module report per cycle while the output is free, read out of the low-cell mask registers.
// Reset (aresetn low, synchronous) sets phase 0, clears all masks and loads default limits.
module cell_adc_diagnostic_sequencer #(
    parameter int NUM_MODULES      = cads_pkg::NUM_MODULES_DEF,
    parameter int NUM_PHASES       = cads_pkg::NUM_PHASES_DEF,
    parameter int CELLS_PER_MODULE = cads_pkg::CELLS_PER_MODULE_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cads_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cads_pkg::LIMIT_W-1:0]      cfg_data,
    // Request stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: module_index[2:0], cell_index[6:3], primary_code[22:7],
    // redundant_code[38:23], zero[39]
    input  logic [cads_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: req_type[0]
    input  logic                              s_tuser,
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: out_module[2:0], out_cell[6:3], mismatch_valid[7], mismatch[8],
    // open_wire_map[25:9], phase[28:26], zero[31:29]
    output logic [cads_pkg::M_TDATA_W-1:0]    m_tdata,
    // m_tuser: kind[1:0]
    output logic [cads_pkg::KIND_W-1:0]       m_tuser,
    output logic                              m_tlast
);
    import cads_pkg::*;

    cads_cmd_t          cmd;
    cads_sts_t          sts;
    logic [MOD_W-1:0]   out_module;
    logic [CELL_W-1:0]  out_cell;
    logic               mismatch_valid;
    logic               mismatch;
    logic [MAP_W-1:0]   open_wire_map;
    logic [PHASE_W-1:0] phase;

    // Limits are plain registers and take a write in any cycle.
    assign cfg_ready = 1'b1;
    assign s_tready  = cmd.in_ready;

    cads_ctrl #(
        .NUM_MODULES (NUM_MODULES)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sts     (sts),
        .cmd     (cmd)
    );

    cads_dpath #(
        .NUM_MODULES      (NUM_MODULES),
        .NUM_PHASES       (NUM_PHASES),
        .CELLS_PER_MODULE (CELLS_PER_MODULE)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (s_tvalid),
        .req_type       (s_tuser),
        .module_index   (s_tdata[2:0]),
        .cell_index     (s_tdata[6:3]),
        .primary_code   (s_tdata[22:7]),
        .redundant_code (s_tdata[38:23]),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .kind           (m_tuser),
        .out_module     (out_module),
        .out_cell       (out_cell),
        .mismatch_valid (mismatch_valid),
        .mismatch       (mismatch),
        .open_wire_map  (open_wire_map),
        .phase          (phase),
        .last           (m_tlast),
        .cmd            (cmd),
        .sts            (sts)
    );

    // Pack the result fields, lowest field first.
    assign m_tdata = {3'b000, phase, open_wire_map, mismatch, mismatch_valid,
                      out_cell, out_module};

endmodule

// ===== tb/cell_adc_diagnostic_sequencer_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the cell ADC diagnostic sequencer, built around a behavioral predictor.
module cell_adc_diagnostic_sequencer_test;
    import cads_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int RANDOM_ITEMS   = 310;
    localparam int MAX_GAP        = 10;
    localparam int HOLD_AT_RESULT = 80;
    localparam int HOLD_CYCLES    = 120;
    localparam int REPORT_LIMIT   = 10;
    localparam int NUM_ROWS       = 21;
    localparam int CELLS          = CELLS_PER_MODULE_DEF;

    // One result as it leaves the block.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [MOD_W-1:0]   mod_id;
        logic [CELL_W-1:0]  cell_id;
        logic               mm_valid;
        logic               mm_flag;
        logic [MAP_W-1:0]   wire_map;
        logic [PHASE_W-1:0] phase_id;
        logic               last_flag;
    } result_t;

    // One request, with a hand-written expectation where typed is set.
    typedef struct packed {
        logic                     req;
        logic [MOD_W-1:0]         mod;
        logic [CELL_W-1:0]        cell_pos;
        logic signed [CODE_W-1:0] prim;
        logic signed [CODE_W-1:0] red;
        logic                     typed;
        result_t                  exp;
    } stim_row_t;

    localparam result_t NO_RESULT = '0;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LIMIT_W-1:0]   cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]    m_tuser;
    logic                 m_tlast;

    // Predictor state: phase, per-module low-cell masks and the two limits.
    logic [PHASE_W-1:0]        cur_phase;
    logic [CELLS-1:0]          low_mask [NUM_MODULES_DEF];
    logic [LIMIT_W-1:0]        lim_mismatch;
    logic signed [LIMIT_W-1:0] lim_open_wire;

    result_t pending_results [$];

    int  fail_count;
    int  results_seen;
    int  reports_seen;
    int  mismatch_flags;
    int  samples_sent;
    int  passes_sent;
    int  cfg_writes;
    int  idle_cycles;
    bit  send_no_idle;
    bit  recv_no_idle;

    cell_adc_diagnostic_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Directed requests: limit edges and code extremes in the redundant phase,
    // set and clear of low bits in both open-wire phases, and a pause sample.
    stim_row_t directed_rows [NUM_ROWS] = '{
        '{REQ_SAMPLE, 3'd0, 4'd0, 16'sd0, 16'sd0, 1'b1,
          '{KIND_CHECK, 3'd0, 4'd0, 1'b1, 1'b0, 17'd0, PH_REDUNDANT, 1'b1}},
        '{REQ_SAMPLE, 3'd7, 4'd15, 16'sh7FFF, 16'sh8000, 1'b1,
          '{KIND_CHECK, 3'd7, 4'd15, 1'b1, 1'b1, 17'd0, PH_REDUNDANT, 1'b1}},
        '{REQ_SAMPLE, 3'd3, 4'd5, 16'sh8000, 16'sh7FFF, 1'b1,
          '{KIND_CHECK, 3'd3, 4'd5, 1'b1, 1'b1, 17'd0, PH_REDUNDANT, 1'b1}},
        '{REQ_SAMPLE, 3'd1, 4'd2, 16'sd1333, 16'sd0, 1'b1,
          '{KIND_CHECK, 3'd1, 4'd2, 1'b1, 1'b0, 17'd0, PH_REDUNDANT, 1'b1}},
        '{REQ_SAMPLE, 3'd2, 4'd9, 16'sd0, 16'sd1334, 1'b1,
          '{KIND_CHECK, 3'd2, 4'd9, 1'b1, 1'b1, 17'd0, PH_REDUNDANT, 1'b1}},
        '{REQ_END_PASS, 3'd0, 4'd0, 16'sd0, 16'sd0, 1'b1,
          '{KIND_ADVANCE, 3'd0, 4'd0, 1'b0, 1'b0, 17'd0, PH_OW_ODD, 1'b1}},
        '{REQ_SAMPLE, 3'd0, 4'd1, 16'sd100, 16'sh8000, 1'b1,
          '{KIND_CHECK, 3'd0, 4'd1, 1'b0, 1'b0, 17'd0, PH_OW_ODD, 1'b1}},
        '{REQ_SAMPLE, 3'd0, 4'd3, 16'sd0, -16'sd6667, 1'b0, NO_RESULT},
        '{REQ_SAMPLE, 3'd0, 4'd5, 16'sd0, 16'sh8000, 1'b0, NO_RESULT},
        '{REQ_SAMPLE, 3'd0, 4'd5, 16'sd0, -16'sd6666, 1'b0, NO_RESULT},
        '{REQ_SAMPLE, 3'd0, 4'd2, 16'sh8000, 16'sh8000, 1'b0, NO_RESULT},
        '{REQ_SAMPLE, 3'd7, 4'd15, 16'sh7FFF, -16'sd20000, 1'b0, NO_RESULT},
        '{REQ_END_PASS, 3'd0, 4'd0, 16'sd0, 16'sd0, 1'b0, NO_RESULT},
        '{REQ_SAMPLE, 3'd0, 4'd0, 16'sd0, 16'sh8000, 1'b0, NO_RESULT},
        '{REQ_SAMPLE, 3'd0, 4'd2, 16'sd0, 16'sh7FFF, 1'b0, NO_RESULT},
        '{REQ_SAMPLE, 3'd7, 4'd14, 16'sd0, 16'sh8000, 1'b0, NO_RESULT},
        '{REQ_SAMPLE, 3'd1, 4'd0, 16'sd0, -16'sd10000, 1'b0, NO_RESULT},
        '{REQ_SAMPLE, 3'd2, 4'd14, 16'sd0, -16'sd10000, 1'b0, NO_RESULT},
        '{REQ_END_PASS, 3'd0, 4'd0, 16'sd0, 16'sd0, 1'b0, NO_RESULT},
        '{REQ_SAMPLE, 3'd4, 4'd4, 16'sd1234, 16'sh8000, 1'b0, NO_RESULT},
        '{REQ_END_PASS, 3'd0, 4'd0, 16'sd0, 16'sd0, 1'b1,
          '{KIND_ADVANCE, 3'd0, 4'd0, 1'b0, 1'b0, 17'd0, PH_REDUNDANT, 1'b1}}
    };

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Sense wire w is open when the cells on both sides of it read low; the two
    // end wires only see one cell and need its neighbor to read normal.
    function automatic logic [MAP_W-1:0] open_wire_map_of(input logic [CELLS-1:0] m);
        logic [MAP_W-1:0] map;
        map = '0;
        for (int j = 1; j < CELLS; j++)
            if (m[j-1] && m[j]) map[j] = 1'b1;
        if (m[1:0] == 2'b01) map[0] = 1'b1;
        if (m[CELLS-1 -: 2] == 2'b10) map[CELLS] = 1'b1;
        return map;
    endfunction

    // Predicts the results of one request and updates the predictor state.
    function automatic int predict_diagnostics(input stim_row_t row,
                                               output result_t res [MAX_REPORTS]);
        int                 diff;
        int                 limit_val;
        int                 count;
        logic [PHASE_W-1:0] ph;
        logic [PHASE_W-1:0] np;
        ph = cur_phase;
        for (int i = 0; i < MAX_REPORTS; i++) res[i] = NO_RESULT;
        if (row.req == REQ_SAMPLE) begin
            // Pause phases and out-of-range positions give nothing.
            if (ph > PH_OW_EVEN || int'(row.mod) >= NUM_MODULES_DEF
                || int'(row.cell_pos) >= CELLS)
                return 0;
            res[0].kind      = KIND_CHECK;
            res[0].mod_id    = row.mod;
            res[0].cell_id   = row.cell_pos;
            res[0].phase_id  = ph;
            res[0].last_flag = 1'b1;
            if (ph == PH_REDUNDANT) begin
                diff = row.prim - row.red;
                if (diff < 0) diff = -diff;
                limit_val = int'(lim_mismatch);
                res[0].mm_valid = 1'b1;
                res[0].mm_flag  = (diff > limit_val);
            end else if ((ph == PH_OW_ODD && row.cell_pos[0])
                         || (ph == PH_OW_EVEN && !row.cell_pos[0]))
            begin
                low_mask[row.mod][row.cell_pos] = (row.red < lim_open_wire);
            end
            return 1;
        end
        np = PHASE_W'((int'(ph) + 1) % NUM_PHASES_DEF);
        cur_phase = np;
        // After an open-wire phase every module reports its wire map.
        if (ph == PH_OW_ODD || ph == PH_OW_EVEN) begin
            count = (NUM_MODULES_DEF < MAX_REPORTS) ? NUM_MODULES_DEF : MAX_REPORTS;
            for (int i = 0; i < count; i++) begin
                res[i].kind      = KIND_REPORT;
                res[i].mod_id    = MOD_W'(i);
                res[i].wire_map  = open_wire_map_of(low_mask[i]);
                res[i].phase_id  = np;
                res[i].last_flag = (i == count - 1);
            end
            return count;
        end
        res[0].kind      = KIND_ADVANCE;
        res[0].phase_id  = np;
        res[0].last_flag = 1'b1;
        return 1;
    endfunction

    // Random idle length, with stretches that have no idling at all.
    function automatic int draw_gap(inout bit no_idle);
        if ($urandom_range(0, 15) == 0) no_idle = !no_idle;
        return no_idle ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    // Builds a cell sample with random codes, often placed near the limit of the current phase or at the code extremes.
    function automatic stim_row_t make_sample();
        stim_row_t row;
        int        p;
        int        d;
        row          = '0;
        row.req      = REQ_SAMPLE;
        row.mod      = MOD_W'($urandom_range(0, NUM_MODULES_DEF - 1));
        row.cell_pos = CELL_W'($urandom_range(0, CELLS - 1));
        row.prim     = CODE_W'($urandom);
        row.red      = CODE_W'($urandom);
        case (cur_phase)
            PH_REDUNDANT: begin
                case ($urandom_range(0, 3))
                    0: ;
                    1: begin
                        p = row.prim;
                        d = int'(lim_mismatch) + int'($urandom_range(0, 2)) - 1;
                        if ($urandom_range(0, 1) == 1) d = -d;
                        row.red = CODE_W'(p - d);
                    end
                    2: row.red = row.prim;
                    default: begin
                        row.prim = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                        row.red  = ~row.prim;
                    end
                endcase
            end
            PH_OW_ODD, PH_OW_EVEN: begin
                // Mostly cells of the parity under test.
                if ($urandom_range(0, 3) != 0) row.cell_pos[0] = (cur_phase == PH_OW_ODD);
                case ($urandom_range(0, 3))
                    0: ;
                    1: row.red = CODE_W'(int'(lim_open_wire) + int'($urandom_range(0, 2)) - 1);
                    2: row.red = 16'sh8000;
                    default: row.red = 16'sh7FFF;
                endcase
            end
            default: ;
        endcase
        return row;
    endfunction

    // End-of-pass request with random content in the unused fields.
    function automatic stim_row_t make_end_pass();
        stim_row_t row;
        row          = '0;
        row.req      = REQ_END_PASS;
        row.mod      = MOD_W'($urandom);
        row.cell_pos = CELL_W'($urandom);
        row.prim     = CODE_W'($urandom);
        row.red      = CODE_W'($urandom);
        return row;
    endfunction

    // Offers one request and queues its expected results once it is taken.
    task automatic send_request(input stim_row_t row);
        result_t res [MAX_REPORTS];
        int      n;
        int      gap;
        gap = draw_gap(send_no_idle);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= row.req;
        s_tdata  <= {1'b0, row.red, row.prim, row.cell_pos, row.mod};
        do @(posedge aclk); while (!s_tready);
        n = predict_diagnostics(row, res);
        if (row.req == REQ_SAMPLE) samples_sent++;
        else passes_sent++;
        if (row.typed) pending_results.push_back(row.exp);
        else for (int i = 0; i < n; i++) pending_results.push_back(res[i]);
    endtask

    // Stops offering requests and waits until every expected result is out.
    task automatic drain_requests();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Issues one register write request; cfg_valid stays high for the caller to drop.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [LIMIT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_MISMATCH_LIMIT) lim_mismatch = value;
        else lim_open_wire = value;
        cfg_writes++;
    endtask

    // New limits while idle: the first two rounds take the extremes.
    task automatic reconfigure(input int round);
        logic [LIMIT_W-1:0] mm_val;
        logic [LIMIT_W-1:0] ow_val;
        int                 which;
        which = (round < 2) ? 2 : int'($urandom_range(0, 2));
        if (round == 0) begin
            mm_val = 16'h0000;
            ow_val = 16'h8000;
        end else if (round == 1) begin
            mm_val = 16'hFFFF;
            ow_val = 16'h7FFF;
        end else begin
            case ($urandom_range(0, 3))
                0: mm_val = MISMATCH_LIMIT_RST;
                1: mm_val = LIMIT_W'($urandom);
                default: mm_val = LIMIT_W'($urandom_range(0, 4000));
            endcase
            case ($urandom_range(0, 2))
                0: ow_val = OPEN_WIRE_LIMIT_RST;
                default: ow_val = LIMIT_W'($urandom);
            endcase
        end
        if (which != 1) write_register(CFG_MISMATCH_LIMIT, mm_val);
        if (which != 0) write_register(CFG_OPEN_WIRE_LIMIT, ow_val);
        cfg_valid <= 1'b0;
    endtask

    // Result receiver: random stalls, plus one long hold-off that backs up the block.
    initial begin : result_sink
        int  gap;
        bit  hold_done;
        int  taken;
        hold_done = 1'b0;
        taken     = 0;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (!hold_done && taken >= HOLD_AT_RESULT) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                gap = draw_gap(recv_no_idle);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
        end
    end

    // Result checker: compares every accepted result with the oldest expectation.
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind      = m_tuser;
            got.mod_id    = m_tdata[2:0];
            got.cell_id   = m_tdata[6:3];
            got.mm_valid  = m_tdata[7];
            got.mm_flag   = m_tdata[8];
            got.wire_map  = m_tdata[25:9];
            got.phase_id  = m_tdata[28:26];
            got.last_flag = m_tlast;
            results_seen++;
            if (got.kind == KIND_REPORT) reports_seen++;
            if (got.mm_flag) mismatch_flags++;
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("ERROR %0t: unexpected result kind %0d module %0d cell %0d",
                             $realtime, got.kind, got.mod_id, got.cell_id);
            end else begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind || got.mod_id !== want.mod_id ||
                    got.cell_id !== want.cell_id || got.mm_valid !== want.mm_valid ||
                    got.mm_flag !== want.mm_flag || got.wire_map !== want.wire_map ||
                    got.phase_id !== want.phase_id || got.last_flag !== want.last_flag) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("ERROR %0t: exp kind %0d mod %0d cell %0d mv %0b mm %0b map %h ph %0d last %0b",
                                 $realtime, want.kind, want.mod_id, want.cell_id, want.mm_valid,
                                 want.mm_flag, want.wire_map, want.phase_id, want.last_flag);
                        $display("         got kind %0d mod %0d cell %0d mv %0b mm %0b map %h ph %0d last %0b",
                                 got.kind, got.mod_id, got.cell_id, got.mm_valid,
                                 got.mm_flag, got.wire_map, got.phase_id, got.last_flag);
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when no request or result moves for too long.
    initial begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: %0d cycles without any handshake", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // Main sequence: reset, directed table, random passes, drain, verdict.
    initial begin : stimulus
        int        counted;
        int        n;
        int        round;
        stim_row_t row;
        counted        = 0;
        round          = 0;
        fail_count     = 0;
        results_seen   = 0;
        reports_seen   = 0;
        mismatch_flags = 0;
        samples_sent   = 0;
        passes_sent    = 0;
        cfg_writes     = 0;
        send_no_idle   = 1'b0;
        recv_no_idle   = 1'b0;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_MISMATCH_LIMIT;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= REQ_SAMPLE;
        cur_phase     = PH_REDUNDANT;
        lim_mismatch  = MISMATCH_LIMIT_RST;
        lim_open_wire = OPEN_WIRE_LIMIT_RST;
        for (int i = 0; i < NUM_MODULES_DEF; i++) low_mask[i] = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < NUM_ROWS; r++) send_request(directed_rows[r]);

        // Random passes: samples of one phase closed by an end of pass, with
        // an occasional premature end of pass and reconfiguration between passes.
        while (counted < RANDOM_ITEMS) begin
            n = (cur_phase > PH_OW_EVEN) ? int'($urandom_range(0, 3))
                                         : int'($urandom_range(1, 14));
            for (int k = 0; k < n; k++) begin
                if (cur_phase <= PH_OW_EVEN) counted++;
                row = make_sample();
                send_request(row);
                if ($urandom_range(0, 19) == 0) begin
                    send_request(make_end_pass());
                    counted++;
                end
            end
            send_request(make_end_pass());
            counted++;
            if (round < 2 || $urandom_range(0, 4) == 0) begin
                drain_requests();
                reconfigure(round);
                round++;
            end
        end
        drain_requests();

        $display("Run covered %0d cell samples, %0d end-of-pass requests, %0d register writes.",
                 samples_sent, passes_sent, cfg_writes);
        $display("Checked %0d results: %0d open-wire reports, %0d mismatches flagged.",
                 results_seen, reports_seen, mismatch_flags);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Failures: %0d, results still expected: %0d",
                     fail_count, pending_results.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule
